### design/spp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo projection package
// Register index codes and fixed counts shared by the projection block.
// ----------------------------------------------------------------------------
package spp_pkg;

  // Register index, taken from the configuration byte address.
  localparam int REG_IDX_BITS = 3;
  typedef logic [REG_IDX_BITS-1:0] reg_idx_t;

  localparam reg_idx_t REG_FOCAL_X    = 3'd0;
  localparam reg_idx_t REG_FOCAL_Y    = 3'd1;
  localparam reg_idx_t REG_CENTER_X   = 3'd2;
  localparam reg_idx_t REG_CENTER_Y   = 3'd3;
  localparam reg_idx_t REG_BASELINE_X = 3'd4;
  localparam reg_idx_t REG_BASELINE_Y = 3'd5;

  // Number of quotients per point; the first ones divide by depth,
  // the rest by depth squared.
  localparam int NUM_QUOT  = 10;
  localparam int NUM_DEN_Z = 6;

endpackage

### design/spp_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo projection register file
// APB-style write and read access to the camera intrinsics and baselines.
// ----------------------------------------------------------------------------
module spp_cfg import spp_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16,
  parameter int CFG_BITS  = 32,
  parameter int ADDR_BITS = 5,
  parameter int ADDR_LSB  = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ADDR_BITS-1:0]        paddr,
  input  logic [CFG_BITS-1:0]         pwdata,
  output logic [CFG_BITS-1:0]         prdata,
  output logic [WORD_BITS-2:0]        focal_x,
  output logic [WORD_BITS-2:0]        focal_y,
  output logic [WORD_BITS-2:0]        center_x,
  output logic [WORD_BITS-2:0]        center_y,
  output logic signed [WORD_BITS-1:0] baseline_x,
  output logic signed [WORD_BITS-1:0] baseline_y
);

  localparam logic [WORD_BITS-2:0] ONE = (WORD_BITS-1)'(1) << FRAC_BITS;

  logic [WORD_BITS-2:0]        focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic signed [WORD_BITS-1:0] baseline_x_r, baseline_y_r;
  reg_idx_t                    idx;
  logic                        wr_en;

  assign idx   = reg_idx_t'(paddr >> ADDR_LSB);
  assign wr_en = psel & penable & pwrite;

  // Register writes complete in the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r    <= ONE;
      focal_y_r    <= ONE;
      center_x_r   <= ONE;
      center_y_r   <= ONE;
      baseline_x_r <= '0;
      baseline_y_r <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_FOCAL_X:    focal_x_r    <= pwdata[WORD_BITS-2:0];
        REG_FOCAL_Y:    focal_y_r    <= pwdata[WORD_BITS-2:0];
        REG_CENTER_X:   center_x_r   <= pwdata[WORD_BITS-2:0];
        REG_CENTER_Y:   center_y_r   <= pwdata[WORD_BITS-2:0];
        REG_BASELINE_X: baseline_x_r <= pwdata[WORD_BITS-1:0];
        REG_BASELINE_Y: baseline_y_r <= pwdata[WORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read data, zero-extended to the bus width.
  always_comb begin
    case (idx)
      REG_FOCAL_X:    prdata = CFG_BITS'(focal_x_r);
      REG_FOCAL_Y:    prdata = CFG_BITS'(focal_y_r);
      REG_CENTER_X:   prdata = CFG_BITS'(center_x_r);
      REG_CENTER_Y:   prdata = CFG_BITS'(center_y_r);
      REG_BASELINE_X: prdata = CFG_BITS'(unsigned'(baseline_x_r));
      REG_BASELINE_Y: prdata = CFG_BITS'(unsigned'(baseline_y_r));
      default:        prdata = '0;
    endcase
  end

  assign focal_x    = focal_x_r;
  assign focal_y    = focal_y_r;
  assign center_x   = center_x_r;
  assign center_y   = center_y_r;
  assign baseline_x = baseline_x_r;
  assign baseline_y = baseline_y_r;

endmodule

### design/spp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo projection numerator stages
// Four register stages: input capture, products, sums, scaled numerators.
// ----------------------------------------------------------------------------
module spp_front import spp_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16,
  parameter int NUM_BITS  = 81,
  parameter int DEN_BITS  = 64
) (
  input  logic                        clk,
  input  logic                        ce,
  input  logic signed [WORD_BITS-1:0] point_x,
  input  logic signed [WORD_BITS-1:0] point_y,
  input  logic signed [WORD_BITS-1:0] point_z,
  input  logic [WORD_BITS-2:0]        focal_x,
  input  logic [WORD_BITS-2:0]        focal_y,
  input  logic [WORD_BITS-2:0]        center_x,
  input  logic [WORD_BITS-2:0]        center_y,
  input  logic signed [WORD_BITS-1:0] baseline_x,
  input  logic signed [WORD_BITS-1:0] baseline_y,
  output logic signed [NUM_BITS-1:0]  num [NUM_QUOT],
  output logic [DEN_BITS-1:0]         den_z,
  output logic [DEN_BITS-1:0]         den_zz
);

  localparam int PW = 2 * WORD_BITS;

  // Stage 1: input capture.
  logic signed [WORD_BITS-1:0] x1_r, y1_r, z1_r;
  // Stage 2: products.
  logic signed [PW-1:0] fxx2_r, fyy2_r, cxz2_r, cyz2_r, zz2_r;
  logic signed [WORD_BITS-1:0] z2_r;
  // Stage 3: sums.
  logic signed [NUM_BITS-1:0] nxl3_r, nyl3_r, fxb3_r, fyb3_r, fxx3_r, fyy3_r;
  logic signed [PW-1:0] zz3_r;
  logic signed [WORD_BITS-1:0] z3_r;
  // Stage 4: numerators and denominators.
  logic signed [NUM_BITS-1:0] num4_r [NUM_QUOT];
  logic [DEN_BITS-1:0] den_z4_r, den_zz4_r;

  logic signed [NUM_BITS-1:0] bxs, bys;
  logic signed [NUM_BITS-1:0] num4_nxt [NUM_QUOT];

  // Baselines scaled up by one fraction unit.
  assign bxs = NUM_BITS'(baseline_x) <<< FRAC_BITS;
  assign bys = NUM_BITS'(baseline_y) <<< FRAC_BITS;

  // Numerator set in output order.
  always_comb begin
    num4_nxt[0] = nxl3_r;
    num4_nxt[1] = nyl3_r;
    num4_nxt[2] = nxl3_r + bxs;
    num4_nxt[3] = nyl3_r + bys;
    num4_nxt[4] = $signed(NUM_BITS'(focal_x)) <<< FRAC_BITS;
    num4_nxt[5] = $signed(NUM_BITS'(focal_y)) <<< FRAC_BITS;
    num4_nxt[6] = -(fxx3_r <<< FRAC_BITS);
    num4_nxt[7] = -(fyy3_r <<< FRAC_BITS);
    num4_nxt[8] = -(fxb3_r <<< FRAC_BITS);
    num4_nxt[9] = -(fyb3_r <<< FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x1_r <= point_x;
      y1_r <= point_y;
      z1_r <= point_z;

      fxx2_r <= $signed({1'b0, focal_x}) * x1_r;
      fyy2_r <= $signed({1'b0, focal_y}) * y1_r;
      cxz2_r <= $signed({1'b0, center_x}) * z1_r;
      cyz2_r <= $signed({1'b0, center_y}) * z1_r;
      zz2_r  <= z1_r * z1_r;
      z2_r   <= z1_r;

      nxl3_r <= NUM_BITS'(fxx2_r) + NUM_BITS'(cxz2_r);
      nyl3_r <= NUM_BITS'(fyy2_r) + NUM_BITS'(cyz2_r);
      fxb3_r <= NUM_BITS'(fxx2_r) + bxs;
      fyb3_r <= NUM_BITS'(fyy2_r) + bys;
      fxx3_r <= NUM_BITS'(fxx2_r);
      fyy3_r <= NUM_BITS'(fyy2_r);
      zz3_r  <= zz2_r;
      z3_r   <= z2_r;

      num4_r    <= num4_nxt;
      den_z4_r  <= DEN_BITS'(unsigned'(z3_r));
      den_zz4_r <= DEN_BITS'(unsigned'(zz3_r));
    end
  end

  assign num    = num4_r;
  assign den_z  = den_z4_r;
  assign den_zz = den_zz4_r;

endmodule

### design/spp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo projection pipelined divider
// Floor division of a signed numerator by a positive denominator, one
// quotient bit per stage, saturated to the signed word range.
// ----------------------------------------------------------------------------
module spp_div #(
  parameter int WORD_BITS = 32,
  parameter int NUM_BITS  = 81,
  parameter int DEN_BITS  = 64
) (
  input  logic                        clk,
  input  logic                        ce,
  input  logic signed [NUM_BITS-1:0]  num,
  input  logic [DEN_BITS-1:0]         den,
  output logic signed [WORD_BITS-1:0] quo
);

  localparam int TOP_BITS = NUM_BITS - WORD_BITS;
  localparam int REM_BITS = (TOP_BITS > DEN_BITS) ? TOP_BITS : DEN_BITS;

  // Stage A: magnitude and sign.
  logic                neg_a_r;
  logic [NUM_BITS-1:0] mag_a_r;
  logic [DEN_BITS-1:0] den_a_r;
  logic [NUM_BITS-1:0] mag_a_nxt;

  // Stage B: overflow check and first partial remainder.
  logic                 neg_b_r, ovf_b_r;
  logic [REM_BITS-1:0]  rem_b_r, den_b_r;
  logic [WORD_BITS-1:0] low_b_r;
  logic [REM_BITS-1:0]  top_b_nxt;

  // Quotient stages: the low word shifts out numerator bits and in quotient bits.
  logic [REM_BITS-1:0]  rem_s_r [WORD_BITS];
  logic [REM_BITS-1:0]  den_s_r [WORD_BITS];
  logic [WORD_BITS-1:0] low_s_r [WORD_BITS];
  logic [WORD_BITS-1:0] neg_s_r, ovf_s_r;
  logic [REM_BITS-1:0]  rem_s_nxt [WORD_BITS];
  logic [REM_BITS-1:0]  den_s_nxt [WORD_BITS];
  logic [WORD_BITS-1:0] low_s_nxt [WORD_BITS];
  logic [WORD_BITS-1:0] neg_s_nxt, ovf_s_nxt;

  // Stage E: rounding and saturation.
  logic                 neg_e_r;
  logic [WORD_BITS-1:0] mag_e_r;
  logic [WORD_BITS-1:0] mag_e_nxt;
  logic [WORD_BITS:0]   magq, lim;

  assign mag_a_nxt = num[NUM_BITS-1] ? (~num + 1'b1) : num;
  assign top_b_nxt = REM_BITS'(mag_a_r[NUM_BITS-1:WORD_BITS]);

  // One restoring step per stage.
  always_comb begin
    logic [REM_BITS-1:0]  rin, din;
    logic [WORD_BITS-1:0] lin;
    logic                 nin, oin;
    logic [REM_BITS:0]    trial;
    logic                 ge;
    for (int k = 0; k < WORD_BITS; k++) begin
      if (k == 0) begin
        rin = rem_b_r;
        din = den_b_r;
        lin = low_b_r;
        nin = neg_b_r;
        oin = ovf_b_r;
      end else begin
        rin = rem_s_r[k-1];
        din = den_s_r[k-1];
        lin = low_s_r[k-1];
        nin = neg_s_r[k-1];
        oin = ovf_s_r[k-1];
      end
      trial = {rin, lin[WORD_BITS-1]};
      ge    = trial >= {1'b0, din};
      rem_s_nxt[k] = ge ? REM_BITS'(trial - {1'b0, din}) : trial[REM_BITS-1:0];
      low_s_nxt[k] = {lin[WORD_BITS-2:0], ge};
      den_s_nxt[k] = din;
      neg_s_nxt[k] = nin;
      ovf_s_nxt[k] = oin;
    end
  end

  // Floor toward minus infinity, then clamp to the signed range.
  always_comb begin
    magq = {1'b0, low_s_r[WORD_BITS-1]}
         + (WORD_BITS+1)'(neg_s_r[WORD_BITS-1] & (|rem_s_r[WORD_BITS-1]));
    lim  = neg_s_r[WORD_BITS-1] ? ((WORD_BITS+1)'(1) << (WORD_BITS-1))
                                : (((WORD_BITS+1)'(1) << (WORD_BITS-1)) - 1'b1);
    if (ovf_s_r[WORD_BITS-1] || (magq > lim)) begin
      mag_e_nxt = lim[WORD_BITS-1:0];
    end else begin
      mag_e_nxt = magq[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      neg_a_r <= num[NUM_BITS-1];
      mag_a_r <= mag_a_nxt;
      den_a_r <= den;

      neg_b_r <= neg_a_r;
      ovf_b_r <= top_b_nxt >= REM_BITS'(den_a_r);
      rem_b_r <= top_b_nxt;
      den_b_r <= REM_BITS'(den_a_r);
      low_b_r <= mag_a_r[WORD_BITS-1:0];

      rem_s_r <= rem_s_nxt;
      den_s_r <= den_s_nxt;
      low_s_r <= low_s_nxt;
      neg_s_r <= neg_s_nxt;
      ovf_s_r <= ovf_s_nxt;

      neg_e_r <= neg_s_r[WORD_BITS-1];
      mag_e_r <= mag_e_nxt;
    end
  end

  assign quo = neg_e_r ? (~mag_e_r + 1'b1) : mag_e_r;

endmodule

### design/stereo_point_projection_jacobian.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo point projection with measurement Jacobian
// Projects a camera-frame point into both stereo images and returns the
// nonzero Jacobian entries, all in saturated signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ stream carries one point per beat (x, y, z). The out_ stream
//   returns one beat per point: four pixel coordinates and six Jacobian
//   entries in tdata, and the invalid flag in tuser. A point with zero or
//   negative depth yields invalid = 1 and all-zero data.
//   The cfg_ port holds focal lengths, principal point and baselines; write
//   them only while no point is in flight.
//   An input beat passes four numerator stages, then WORD_BITS + 3
//   divider stages, one per quotient bit plus sign, overflow and rounding
//   stages, then the output register. Throughput is one point per cycle
//   while the output register is free or its beat is taken.
//   When the receiver stalls, the whole pipeline holds and in_tready falls
//   only while a finished beat waits in the output register; nothing is
//   dropped or repeated. Reset clears all valid bits and loads the register
//   defaults: focal lengths and principal point 1.0, baselines 0.
// ----------------------------------------------------------------------------
module stereo_point_projection_jacobian import spp_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16,
  localparam int CFG_BITS  = (WORD_BITS > 32) ? 64 : 32,
  localparam int ADDR_LSB  = (WORD_BITS > 32) ? 3 : 2,
  localparam int ADDR_BITS = $clog2(6 * (1 << ADDR_LSB)),
  localparam int IN_TDATA_BITS  = ((3 * WORD_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA_BITS = ((NUM_QUOT * WORD_BITS + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // point_x, point_y, point_z from the low bits up
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,
  // u_left, v_left, u_right, v_right, du_dx, dv_dy, du_left_dz,
  // dv_left_dz, du_right_dz, dv_right_dz from the low bits up
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TDATA_BITS-1:0] out_tdata,
  // invalid
  output logic                      out_tuser,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [ADDR_BITS-1:0]      cfg_paddr,
  input  logic [CFG_BITS-1:0]       cfg_pwdata,
  output logic [CFG_BITS-1:0]       cfg_prdata,
  output logic                      cfg_pready
);

  localparam int PW       = ((2 * WORD_BITS - 2) > (WORD_BITS + FRAC_BITS - 1))
                            ? (2 * WORD_BITS - 2) : (WORD_BITS + FRAC_BITS - 1);
  localparam int NUM_BITS = PW + 2 + FRAC_BITS + 1;
  localparam int DEN_BITS = 2 * WORD_BITS;
  localparam int LAT      = WORD_BITS + 7;

  logic [WORD_BITS-2:0]        focal_x, focal_y, center_x, center_y;
  logic signed [WORD_BITS-1:0] baseline_x, baseline_y;
  logic signed [WORD_BITS-1:0] point_x, point_y, point_z;
  logic signed [NUM_BITS-1:0]  num [NUM_QUOT];
  logic [DEN_BITS-1:0]         den_z, den_zz;
  logic signed [WORD_BITS-1:0] quo [NUM_QUOT];

  logic [LAT-1:0]       vld_r, inv_r;
  logic                 out_tvalid_r, out_inv_r;
  logic [WORD_BITS-1:0] out_q_r [NUM_QUOT];
  logic                 ce, in_inv;

  // The pipeline moves whenever the output register is free or drains.
  assign ce        = !out_tvalid_r || out_tready;
  assign in_tready = ce;

  assign point_x = in_tdata[WORD_BITS-1:0];
  assign point_y = in_tdata[2*WORD_BITS-1:WORD_BITS];
  assign point_z = in_tdata[3*WORD_BITS-1:2*WORD_BITS];
  assign in_inv  = point_z[WORD_BITS-1] || (point_z == '0);

  assign cfg_pready = 1'b1;

  spp_cfg #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .CFG_BITS  (CFG_BITS),
    .ADDR_BITS (ADDR_BITS),
    .ADDR_LSB  (ADDR_LSB)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .focal_x    (focal_x),
    .focal_y    (focal_y),
    .center_x   (center_x),
    .center_y   (center_y),
    .baseline_x (baseline_x),
    .baseline_y (baseline_y)
  );

  spp_front #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .NUM_BITS  (NUM_BITS),
    .DEN_BITS  (DEN_BITS)
  ) u_front (
    .clk        (clk),
    .ce         (ce),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .focal_x    (focal_x),
    .focal_y    (focal_y),
    .center_x   (center_x),
    .center_y   (center_y),
    .baseline_x (baseline_x),
    .baseline_y (baseline_y),
    .num        (num),
    .den_z      (den_z),
    .den_zz     (den_zz)
  );

  // One divider per output; the first group divides by depth.
  for (genvar i = 0; i < NUM_QUOT; i++) begin : g_div
    spp_div #(
      .WORD_BITS (WORD_BITS),
      .NUM_BITS  (NUM_BITS),
      .DEN_BITS  (DEN_BITS)
    ) u_div (
      .clk (clk),
      .ce  (ce),
      .num (num[i]),
      .den ((i < NUM_DEN_Z) ? den_z : den_zz),
      .quo (quo[i])
    );
  end

  // Valid and invalid flags travel alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else if (ce) begin
      vld_r        <= {vld_r[LAT-2:0], in_tvalid};
      out_tvalid_r <= vld_r[LAT-1];
    end
  end

  // Output register; invalid points return zeros.
  always_ff @(posedge clk) begin
    if (ce) begin
      inv_r     <= {inv_r[LAT-2:0], in_inv};
      out_inv_r <= inv_r[LAT-1];
      for (int i = 0; i < NUM_QUOT; i++) begin
        out_q_r[i] <= inv_r[LAT-1] ? '0 : quo[i];
      end
    end
  end

  always_comb begin
    out_tdata = '0;
    for (int i = 0; i < NUM_QUOT; i++) begin
      out_tdata[i*WORD_BITS +: WORD_BITS] = out_q_r[i];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_inv_r;

endmodule

### dv/tb_stereo_point_projection_jacobian.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo point projection testbench
// Streams camera-frame points through the projection block under random
// handshake gaps on both sides. Each beat is predicted with exact
// wide-integer arithmetic, rounding toward minus infinity and saturating.
// The predicted beat is then checked field by field against the block's
// output, across several camera register settings.
// ----------------------------------------------------------------------------
module tb_stereo_point_projection_jacobian;
  import spp_pkg::*;

  localparam int W = 32;
  localparam int FRAC = 16;
  localparam int LATENCY = W + 8;
  localparam int STALL_LIMIT = 5000;

  typedef logic signed [191:0] wide_t;
  typedef struct packed {
    logic signed [W-1:0] z;
    logic signed [W-1:0] y;
    logic signed [W-1:0] x;
  } point_t;
  typedef struct {
    logic [NUM_QUOT*W-1:0] data;
    logic                  invalid;
  } proj_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [NUM_QUOT*W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // Camera settings as the predictor sees them.
  logic [30:0] cam_fx, cam_fy, cam_cx, cam_cy;
  logic signed [31:0] cam_bx, cam_by;

  point_t point_q[$];
  proj_t proj_q[$];
  int errors = 0;
  bit quiet = 1'b0;
  bit in_taken = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  int idle_cycles = 0;

  string field_name[NUM_QUOT] = '{"u_left", "v_left", "u_right", "v_right", "du_dx",
    "dv_dy", "du_left_dz", "dv_left_dz", "du_right_dz", "dv_right_dz"};

  stereo_point_projection_jacobian u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Floor division by a positive divisor, saturated to the word range.
  function automatic logic [W-1:0] floor_div_sat(wide_t n, wide_t d);
    wide_t q;
    q = n / d;
    if (n < 0 && (n % d) != 0) q = q - 1;
    if (q > wide_t'(32'sh7fffffff)) q = wide_t'(32'sh7fffffff);
    if (q < -wide_t'(64'sh80000000)) q = -wide_t'(64'sh80000000);
    return q[W-1:0];
  endfunction

  // Projects one point with the current camera settings.
  function automatic proj_t project_point(point_t p);
    proj_t r;
    wide_t x, y, z, zz, fx, fy, fxx, fyy, bxs, bys, nxl, nyl;
    logic [W-1:0] q[NUM_QUOT];
    r.data = '0;
    r.invalid = 1'b1;
    if (p.z <= 0) return r;
    x = {{160{p.x[W-1]}}, p.x};
    y = {{160{p.y[W-1]}}, p.y};
    z = {{160{p.z[W-1]}}, p.z};
    fx = {161'd0, cam_fx};
    fy = {161'd0, cam_fy};
    zz = z * z;
    fxx = fx * x;
    fyy = fy * y;
    bxs = {{160{cam_bx[W-1]}}, cam_bx} <<< FRAC;
    bys = {{160{cam_by[W-1]}}, cam_by} <<< FRAC;
    nxl = fxx + {161'd0, cam_cx} * z;
    nyl = fyy + {161'd0, cam_cy} * z;
    q[0] = floor_div_sat(nxl, z);
    q[1] = floor_div_sat(nyl, z);
    q[2] = floor_div_sat(nxl + bxs, z);
    q[3] = floor_div_sat(nyl + bys, z);
    q[4] = floor_div_sat(fx <<< FRAC, z);
    q[5] = floor_div_sat(fy <<< FRAC, z);
    q[6] = floor_div_sat(-(fxx <<< FRAC), zz);
    q[7] = floor_div_sat(-(fyy <<< FRAC), zz);
    q[8] = floor_div_sat(-((fxx + bxs) <<< FRAC), zz);
    q[9] = floor_div_sat(-((fyy + bys) <<< FRAC), zz);
    for (int i = 0; i < NUM_QUOT; i++) r.data[i*W +: W] = q[i];
    r.invalid = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
    errors++;
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Monitor: predicts accepted points and checks result beats.
  always @(posedge clk) begin
    proj_t want;
    in_taken = rst_n && in_tvalid && in_tready;
    if (in_taken) begin
      proj_q.push_back(project_point(point_t'(in_tdata)));
      void'(point_q.pop_front());
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (proj_q.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata[W-1:0], '0);
      end else begin
        want = proj_q.pop_front();
        if (out_tuser !== want.invalid)
          report_mismatch("invalid", W'(out_tuser), W'(want.invalid));
        for (int i = 0; i < NUM_QUOT; i++)
          if (out_tdata[i*W +: W] !== want.data[i*W +: W])
            report_mismatch(field_name[i], out_tdata[i*W +: W], want.data[i*W +: W]);
      end
    end
  end

  // Watchdog: counts stuck cycles while work is outstanding.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (point_q.size() == 0 && proj_q.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Driver: feeds queued points with random gap bursts.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      in_tvalid <= 1'b1;
    end else if (in_gap > 0) begin
      in_gap--;
      in_tvalid <= 1'b0;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      in_gap = $urandom_range(0, 15);
      in_tvalid <= 1'b0;
    end else if (point_q.size() > 0) begin
      in_tdata <= point_q[0];
      in_tvalid <= 1'b1;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver: stalls in random bursts.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // One register write: setup beat, then access beat.
  task automatic cfg_write(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    case (idx)
      REG_FOCAL_X:    cam_fx = value[30:0];
      REG_FOCAL_Y:    cam_fy = value[30:0];
      REG_CENTER_X:   cam_cx = value[30:0];
      REG_CENTER_Y:   cam_cy = value[30:0];
      REG_BASELINE_X: cam_bx = value;
      REG_BASELINE_Y: cam_by = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic set_camera(logic [31:0] fx, logic [31:0] fy, logic [31:0] cx,
                            logic [31:0] cy, logic [31:0] bx, logic [31:0] by);
    cfg_write(REG_FOCAL_X, fx);
    cfg_write(REG_FOCAL_Y, fy);
    cfg_write(REG_CENTER_X, cx);
    cfg_write(REG_CENTER_Y, cy);
    cfg_write(REG_BASELINE_X, bx);
    cfg_write(REG_BASELINE_Y, by);
  endtask

  // Waits until every point has come back and the pipe is empty.
  task automatic drain();
    wait (point_q.size() == 0 && proj_q.size() == 0 && !in_tvalid);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  function automatic point_t pt(int x, int y, int z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    return p;
  endfunction

  // Mostly plausible scene points, plus full-range, non-positive and tiny depths.
  function automatic point_t random_point();
    int sel;
    point_t p;
    sel = $urandom_range(0, 99);
    p.x = $urandom;
    p.y = $urandom;
    p.z = $urandom;
    if (sel < 65) begin
      p.x = $signed(p.x) >>> $urandom_range(4, 20);
      p.y = $signed(p.y) >>> $urandom_range(4, 20);
      p.z = $urandom_range(1, 32'h03ff_ffff) >> $urandom_range(0, 12);
      if (p.z == 0) p.z = 1;
    end else if (sel < 80) begin
    end else if (sel < 90) begin
      p.z = -$signed({1'b0, p.z[30:0]});
    end else begin
      p.z = $urandom_range(1, 16);
    end
    return p;
  endfunction

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) point_q.push_back(random_point());
  endtask

  task automatic queue_directed();
    point_q.push_back(pt(0, 0, 32'h0001_0000));
    point_q.push_back(pt(32'h0001_0000, -32'sh0001_0000, 32'h0002_0000));
    point_q.push_back(pt(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    point_q.push_back(pt(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    point_q.push_back(pt(32'h7fff_ffff, 32'h8000_0000, 1));
    point_q.push_back(pt(32'h8000_0000, 32'h7fff_ffff, 1));
    point_q.push_back(pt(5, -7, 3));
    point_q.push_back(pt(-5, 7, 3));
    point_q.push_back(pt(32'h1234_5678, 32'h9abc_def0, 0));
    point_q.push_back(pt(1, 1, -1));
    point_q.push_back(pt(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000));
    point_q.push_back(pt(-1, -1, 32'h0000_8000));
    point_q.push_back(pt(32'h0010_0000, -32'sh0020_0000, 32'h0050_0000));
    point_q.push_back(pt(0, 0, 32'h7fff_ffff));
  endtask

  initial begin
    cam_fx = 31'h0001_0000;
    cam_fy = 31'h0001_0000;
    cam_cx = 31'h0001_0000;
    cam_cy = 31'h0001_0000;
    cam_bx = '0;
    cam_by = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset defaults.
    queue_directed();
    queue_random(100);
    drain();

    // A typical stereo rig.
    set_camera(32'd500 << 16, 32'd480 << 16, 32'd320 << 16, 32'd240 << 16,
               -32'sd60 << 16, 32'sd3 << 16);
    queue_directed();
    queue_random(250);
    drain();

    // Largest focal lengths and principal point, baselines at both extremes.
    set_camera(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h8000_0000, 32'h7fff_ffff);
    queue_directed();
    queue_random(120);
    drain();

    // Zero focal lengths and principal point; right image equals left.
    set_camera(0, 0, 0, 0, 0, 0);
    queue_random(80);
    drain();

    // Random settings; the top register bit must be dropped, and a write
    // past the last register must change nothing.
    for (int k = 0; k < 3; k++) begin
      set_camera($urandom | 32'h8000_0000, $urandom, $urandom | 32'h8000_0000,
                 $urandom, $urandom, $urandom);
      cfg_write(reg_idx_t'(REG_BASELINE_Y + 1), $urandom);
      queue_random(150);
      drain();
    end

    // Final stretch without any idling.
    set_camera(32'd700 << 16, 32'd700 << 16, 32'd640 << 16, 32'd360 << 16,
               32'sd120 << 16, -32'sd2 << 16);
    quiet = 1'b1;
    queue_random(200);
    drain();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
